// ----- hw/rtl/status_led_color_sequencer_unit_macros.svh -----
// ---------------------------------------------------------------------------
// status led color sequencer assertion macros
// shared concurrent check forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef STATUS_LED_COLOR_SEQUENCER_UNIT_MACROS_SVH
`define STATUS_LED_COLOR_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication
`define SLCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SLCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/slcs_pkg.sv -----
// ---------------------------------------------------------------------------
// slcs_pkg
// types and constants of the status led color sequencer
// ---------------------------------------------------------------------------
package slcs_pkg;

  localparam int unsigned ChanW = 8;

  localparam logic [ChanW-1:0] FULL_LEVEL = 8'hff;

  // last step counts of the shared multiplier and the ramp divider
  localparam logic [2:0] MUL_LAST = 3'd2;
  localparam logic [2:0] DIV_LAST = 3'd7;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_BLINK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } slcs_state_t;

endpackage

// ----- hw/rtl/status_led_color_sequencer_unit.sv -----
// ---------------------------------------------------------------------------
// status_led_color_sequencer_unit
// a tick's color is registered from ST_FIN, entered straight from ST_IDLE in normal
// mode or with a zero period, after the shared 8x8 multiplier (3 steps) with fading,
// and after the 8-step restoring divider for the ramp in blink mode
// in_ready is high only in ST_IDLE: a tick holds the block until it is back in
// ST_IDLE, a blink start does not, and a changed color waits for out_ready
// reset: synchronous, clears fade, blink and last color state to zero
// ---------------------------------------------------------------------------
`include "status_led_color_sequencer_unit_macros.svh"

module status_led_color_sequencer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [3:0]  slot_index,
  input  logic [23:0] user_color,
  input  logic [1:0]  bt_flags,
  input  logic        link_up,
  input  logic [7:0]  blink_count,
  input  logic [7:0]  blink_period,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);
  import slcs_pkg::*;

  slcs_state_t state, state_next;

  logic [7:0]  fade_step;
  logic [7:0]  blink_left;
  logic [7:0]  blink_timer;
  logic [7:0]  blink_length;
  logic [23:0] last_color;

  logic [7:0] col_r, col_g, col_b;
  logic [7:0] rem;
  logic [7:0] quo;
  logic [2:0] cnt;

  logic       accept;
  logic       tick;
  logic       load_out;
  logic       differs;

  // tick decode
  logic [2:0]  code;
  logic [7:0]  base_r, base_g, base_b;
  logic        fade_en;
  logic [7:0]  timer_n, left_n, diff;
  logic [15:0] num;

  // shared multiplier
  logic [7:0]  mul_in;
  logic [15:0] prod;

  // divider step
  logic [8:0] trial;
  logic       ge;
  logic [8:0] trial_sub;
  logic [7:0] rem_next, quo_next;

  assign accept  = in_valid && in_ready;
  assign tick    = accept && (kind == KIND_TICK);
  assign differs = {col_b, col_g, col_r} != last_color;

  always_comb begin
    code    = slot_index[2:0] + 3'd1;
    fade_en = bt_flags[1] && !link_up;
    if (user_color == 24'd0) begin
      base_r = {ChanW{code[2]}};
      base_g = {ChanW{code[0]}};
      base_b = {ChanW{code[1]}};
    end else begin
      base_r = user_color[23:16];
      base_g = user_color[15:8];
      base_b = user_color[7:0];
    end
    if (blink_timer == 8'd0) begin
      timer_n = blink_length;
      left_n  = blink_left - 8'd1;
    end else begin
      timer_n = blink_timer - 8'd1;
      left_n  = blink_left;
    end
    diff = (timer_n > blink_length) ? 8'd0 : (blink_length - timer_n);
    // diff * 255 as a shift and subtract
    num  = {diff, 8'h00} - {8'h00, diff};
  end

  always_comb begin
    unique case (cnt[1:0])
      2'd0:    mul_in = col_r;
      2'd1:    mul_in = col_g;
      default: mul_in = col_b;
    endcase
    prod = mul_in * fade_step;
  end

  always_comb begin
    trial     = {rem, quo[7]};
    ge        = trial >= {1'b0, blink_length};
    trial_sub = trial - {1'b0, blink_length};
    rem_next  = ge ? trial_sub[7:0] : trial[7:0];
    quo_next  = {quo[6:0], ge};
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (tick) begin
          if (blink_left == 8'd0) begin
            state_next = fade_en ? ST_MUL : ST_FIN;
          end else begin
            state_next = (blink_length == 8'd0) ? ST_FIN : ST_DIV;
          end
        end
      end
      ST_MUL: if (cnt == MUL_LAST) state_next = ST_FIN;
      ST_DIV: if (cnt == DIV_LAST) state_next = ST_FIN;
      ST_FIN: if (!differs || !out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_FIN:  load_out = differs && (!out_valid || out_ready);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fade_step    <= 8'd0;
      blink_left   <= 8'd0;
      blink_timer  <= 8'd0;
      blink_length <= 8'd0;
      last_color   <= 24'd0;
      out_valid    <= 1'b0;
      cnt          <= 3'd0;
    end else begin
      state <= state_next;
      if (accept && kind == KIND_BLINK) begin
        blink_left   <= blink_count;
        blink_length <= blink_period;
      end
      if (tick) begin
        cnt <= 3'd0;
        if (blink_left == 8'd0) begin
          if (fade_en) fade_step <= fade_step + 8'd1;
        end else begin
          blink_timer <= timer_n;
          blink_left  <= left_n;
        end
      end else if (state == ST_MUL || state == ST_DIV) begin
        cnt <= cnt + 3'd1;
      end
      if (load_out) begin
        last_color <= {col_b, col_g, col_r};
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (tick) begin
      if (blink_left == 8'd0) begin
        col_r <= base_r;
        col_g <= base_g;
        col_b <= base_b;
      end else begin
        // zero period shows full level, inverted on an even count
        col_r <= left_n[0] ? FULL_LEVEL : ~FULL_LEVEL;
        col_g <= left_n[0] ? FULL_LEVEL : ~FULL_LEVEL;
        col_b <= left_n[0] ? FULL_LEVEL : ~FULL_LEVEL;
        rem   <= num[15:8];
        quo   <= num[7:0];
      end
    end else if (state == ST_MUL) begin
      unique case (cnt[1:0])
        2'd0:    col_r <= prod[15:8];
        2'd1:    col_g <= prod[15:8];
        default: col_b <= prod[15:8];
      endcase
    end else if (state == ST_DIV) begin
      rem <= rem_next;
      quo <= quo_next;
      if (cnt == DIV_LAST) begin
        col_r <= blink_left[0] ? quo_next : ~quo_next;
        col_g <= blink_left[0] ? quo_next : ~quo_next;
        col_b <= blink_left[0] ? quo_next : ~quo_next;
      end
    end
    if (load_out) begin
      red   <= col_r;
      green <= col_g;
      blue  <= col_b;
    end
  end

  `SLCS_ASSERT_NOW(a_out_last, out_valid, {blue, green, red} == last_color, "stale output")
  `SLCS_ASSERT_NOW(a_div_rem_bound, state == ST_DIV, rem < blink_length, "remainder too big")
  `SLCS_ASSERT_NEXT(a_normal_no_div, tick && blink_left == 8'd0, state != ST_DIV, "tick in div")

endmodule
